// ===== hw/rtl/pfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_pkg - pipe descriptor engine shared types
// Opcodes, status codes, descriptor kinds, transaction structs and default
// sizes used by the pipe engine.
// ----------------------------------------------------------------------------
package pfd_pkg;

    localparam int FD_COUNT_DEF   = 16;
    localparam int NUM_PIPES_DEF  = 8;
    localparam int RING_DEPTH_DEF = 64;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_READ   = 2'd1,
        OP_WRITE  = 2'd2,
        OP_CLOSE  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ERROR = 2'd1,
        ST_EOF   = 2'd2,
        ST_BLOCK = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        KIND_FREE  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } t_kind;

    typedef struct packed {
        t_opcode    opcode;
        logic [4:0] fd;
        logic [7:0] data_in;
    } t_item;

    typedef struct packed {
        t_status    status;
        logic [7:0] data_out;
        logic [3:0] read_fd;
        logic [3:0] write_fd;
    } t_result;

endpackage

// ===== hw/rtl/pfd_free_find.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_free_find - lowest two free descriptors
// Priority encoder returning the lowest and second lowest set bits of the
// free map, with a flag when at least two are set.
// ----------------------------------------------------------------------------
module pfd_free_find #(
    parameter int FD_COUNT = 16,
    parameter int FD_W     = 4
) (
    input  logic [FD_COUNT-1:0] i_free,
    output logic                o_found,
    output logic [FD_W-1:0]     o_first,
    output logic [FD_W-1:0]     o_second
);
    logic first_hit;
    logic second_hit;

    always_comb begin
        first_hit  = 1'b0;
        second_hit = 1'b0;
        o_first    = '0;
        o_second   = '0;
        // scan downwards so the lowest match wins
        for (int i = FD_COUNT - 1; i >= 0; i--) begin
            if (i_free[i]) begin
                o_first   = FD_W'(i);
                first_hit = 1'b1;
            end
        end
        for (int i = FD_COUNT - 1; i >= 0; i--) begin
            if (i_free[i] && (FD_W'(i) != o_first)) begin
                o_second   = FD_W'(i);
                second_hit = 1'b1;
            end
        end
        o_found = first_hit && second_hit;
    end

endmodule

// ===== hw/rtl/pfd_ring_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_ring_mem - ring byte storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pfd_ring_mem #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);
    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== hw/rtl/pipe_fd_ring_buffer_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipe_fd_ring_buffer_engine_unit - pipe engine with descriptor table
// Creates pipes, moves single bytes through per-pipe rings and closes
// descriptors, one operation per transaction.
// ----------------------------------------------------------------------------
// The engine takes one transaction every clock cycle: busy is never raised,
// and there is no start-up clearing pass. The accepting edge loads the input
// register; the next edge updates the descriptor and pipe state, performs the
// ring memory access and loads the result register (the data byte comes from
// the memory's registered read port). o_valid therefore follows acceptance
// through the input register and the result register, one strobe per
// accepted transaction. Results come out in acceptance
// order and cannot be held off, so the receiver must take every strobe.
module pipe_fd_ring_buffer_engine_unit #(
    parameter int FD_COUNT   = pfd_pkg::FD_COUNT_DEF,
    parameter int NUM_PIPES  = pfd_pkg::NUM_PIPES_DEF,
    parameter int RING_DEPTH = pfd_pkg::RING_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  pfd_pkg::t_item   i_item,
    output logic             o_valid,
    output pfd_pkg::t_result o_result
);
    import pfd_pkg::*;

    localparam int FD_W   = $clog2(FD_COUNT);
    localparam int PIPE_W = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int USED_W = $clog2(NUM_PIPES + 1);
    localparam int POS_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int MEM_D  = NUM_PIPES * RING_DEPTH;
    localparam int ADDR_W = (MEM_D > 1) ? $clog2(MEM_D) : 1;

    // input register
    logic  r_in_valid;
    t_item r_in;

    // descriptor table
    t_kind             r_fd_kind [FD_COUNT];
    logic [PIPE_W-1:0] r_fd_pipe [FD_COUNT];
    logic [USED_W-1:0] r_pipes_used;

    // per-pipe ring control, valid once the pipe is created
    logic [POS_W-1:0]  r_head    [NUM_PIPES];
    logic [POS_W-1:0]  r_tail    [NUM_PIPES];
    logic [FILL_W-1:0] r_fill    [NUM_PIPES];
    logic              r_rd_open [NUM_PIPES];
    logic              r_wr_open [NUM_PIPES];

    // result register
    logic       r_res_valid;
    t_status    r_status;
    logic [3:0] r_rfd;
    logic [3:0] r_wfd;
    logic       r_rd_ok;
    logic [7:0] mem_q;

    logic [FD_COUNT-1:0] fd_free;
    logic                pair_found;
    logic [FD_W-1:0]     fd_a;
    logic [FD_W-1:0]     fd_b;

    logic [FD_W-1:0]   fd_idx;
    logic              fd_in_range;
    t_kind             kind;
    logic [PIPE_W-1:0] pipe;
    logic              pipe_live;
    logic [PIPE_W-1:0] new_pipe;

    logic              do_create;
    logic              do_read;
    logic              do_write;
    logic              do_close;
    t_status           n_status;
    logic [3:0]        n_rfd;
    logic [3:0]        n_wfd;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_item;
        end
    end

    always_comb begin
        for (int i = 0; i < FD_COUNT; i++) begin
            fd_free[i] = (r_fd_kind[i] == KIND_FREE);
        end
    end

    pfd_free_find #(
        .FD_COUNT (FD_COUNT),
        .FD_W     (FD_W)
    ) u_free_find (
        .i_free   (fd_free),
        .o_found  (pair_found),
        .o_first  (fd_a),
        .o_second (fd_b)
    );

    always_comb begin
        fd_idx      = FD_W'(r_in.fd);
        fd_in_range = (32'(r_in.fd) < FD_COUNT);
        kind        = r_fd_kind[fd_idx];
        pipe        = r_fd_pipe[fd_idx];
        pipe_live   = (USED_W'(pipe) < r_pipes_used);
        new_pipe    = PIPE_W'(r_pipes_used);
        rd_addr     = ADDR_W'(32'(pipe) * RING_DEPTH + 32'(r_tail[pipe]));
        wr_addr     = ADDR_W'(32'(pipe) * RING_DEPTH + 32'(r_head[pipe]));

        do_create = 1'b0;
        do_read   = 1'b0;
        do_write  = 1'b0;
        do_close  = 1'b0;
        n_status  = ST_ERROR;
        n_rfd     = '0;
        n_wfd     = '0;

        case (r_in.opcode)
            OP_CREATE: begin
                if ((r_pipes_used < USED_W'(NUM_PIPES)) && pair_found) begin
                    do_create = r_in_valid;
                    n_status  = ST_OK;
                    n_rfd     = 4'(fd_a);
                    n_wfd     = 4'(fd_b);
                end
            end
            OP_READ: begin
                if (fd_in_range && (kind == KIND_READ) && pipe_live) begin
                    if (r_fill[pipe] == '0) begin
                        n_status = r_wr_open[pipe] ? ST_BLOCK : ST_EOF;
                    end else begin
                        do_read  = r_in_valid;
                        n_status = ST_OK;
                    end
                end
            end
            OP_WRITE: begin
                if (fd_in_range && (kind == KIND_WRITE) && pipe_live
                        && r_rd_open[pipe]) begin
                    if (r_fill[pipe] >= FILL_W'(RING_DEPTH)) begin
                        n_status = ST_BLOCK;
                    end else begin
                        do_write = r_in_valid;
                        n_status = ST_OK;
                    end
                end
            end
            OP_CLOSE: begin
                if (fd_in_range && (kind != KIND_FREE)) begin
                    do_close = r_in_valid;
                    n_status = ST_OK;
                end
            end
            default: begin
                n_status = ST_ERROR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FD_COUNT; i++) begin
                r_fd_kind[i] <= KIND_FREE;
            end
            r_pipes_used <= '0;
        end else begin
            if (do_create) begin
                r_fd_kind[fd_a] <= KIND_READ;
                r_fd_kind[fd_b] <= KIND_WRITE;
                r_pipes_used    <= r_pipes_used + USED_W'(1);
            end
            if (do_close) begin
                r_fd_kind[fd_idx] <= KIND_FREE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_create) begin
            r_fd_pipe[fd_a] <= new_pipe;
            r_fd_pipe[fd_b] <= new_pipe;
        end
    end

    // ring pointers and end flags carry no reset: create sets them first
    always_ff @(posedge i_clk) begin
        if (do_create) begin
            r_head[new_pipe]    <= '0;
            r_tail[new_pipe]    <= '0;
            r_fill[new_pipe]    <= '0;
            r_rd_open[new_pipe] <= 1'b1;
            r_wr_open[new_pipe] <= 1'b1;
        end
        if (do_read) begin
            r_tail[pipe] <= (r_tail[pipe] == POS_W'(RING_DEPTH - 1))
                            ? '0 : r_tail[pipe] + POS_W'(1);
            r_fill[pipe] <= r_fill[pipe] - FILL_W'(1);
        end
        if (do_write) begin
            r_head[pipe] <= (r_head[pipe] == POS_W'(RING_DEPTH - 1))
                            ? '0 : r_head[pipe] + POS_W'(1);
            r_fill[pipe] <= r_fill[pipe] + FILL_W'(1);
        end
        if (do_close) begin
            if (kind == KIND_READ) begin
                r_rd_open[pipe] <= 1'b0;
            end else begin
                r_wr_open[pipe] <= 1'b0;
            end
        end
    end

    pfd_ring_mem #(
        .DEPTH  (MEM_D),
        .ADDR_W (ADDR_W)
    ) u_ring_mem (
        .i_clk     (i_clk),
        .i_wr_en   (do_write),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_in.data_in),
        .i_rd_en   (do_read),
        .i_rd_addr (rd_addr),
        .o_rd_data (mem_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_rfd    <= n_rfd;
        r_wfd    <= n_wfd;
        r_rd_ok  <= do_read;
    end

    assign o_valid           = r_res_valid;
    assign o_result.status   = r_status;
    assign o_result.data_out = r_rd_ok ? mem_q : 8'd0;
    assign o_result.read_fd  = r_rfd;
    assign o_result.write_fd = r_wfd;

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("accepted transaction produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_in_valid))
        else $error("result strobe without a transaction in flight");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && fd_in_range && (kind != KIND_FREE) && pipe_live)
            |-> (32'(r_fill[pipe]) <= RING_DEPTH))
        else $error("ring fill count beyond ring depth");
`endif

endmodule
